### hdl/erc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package erc_pkg;

	localparam int ID_W   = 32;
	localparam int TICK_W = 32;

	localparam logic [2:0] CMD_INSERT   = 3'd0;
	localparam logic [2:0] CMD_ADVANCE  = 3'd1;
	localparam logic [2:0] CMD_RD_CUR   = 3'd2;
	localparam logic [2:0] CMD_RD_PAST  = 3'd3;
	localparam logic [2:0] CMD_FIND     = 3'd4;
	localparam logic [2:0] CMD_CLEAR    = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BACKWARDS = 3'd1;
	localparam logic [2:0] ST_CUR_FULL  = 3'd2;
	localparam logic [2:0] ST_PAST_FULL = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX = 3'd4;

	typedef struct packed {
		logic [2:0]        command;
		logic [ID_W-1:0]   event_id;
		logic [TICK_W-1:0] new_time;
		logic [9:0]        entry_index;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [6:0]        current_count;
		logic [10:0]       past_count;
		logic [ID_W-1:0]   read_event_id;
		logic [TICK_W-1:0] elapsed;
		logic              elapsed_infinite;
		logic              found;
		logic [10:0]       found_index;
	} res_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] tick;
		logic              never;
	} past_entry_t;

endpackage
`default_nettype wire

### hdl/erc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module erc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hdl/event_recency_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear and bad reads go straight to the result, good reads read the memory, insert
// scans the current entries, find runs a binary search with a hit check when the search
// stops inside the table; advance walks the current set twice with a binary search per id
// and shifts the past table for each moved entry.
// One request at a time; the next is taken while a result waits in the output register.
// Reset clears fills and time (minus infinity); memory contents are not cleared.
module event_recency_table
	import erc_pkg::*;
#(
	parameter int CURRENT_DEPTH = 64,
	parameter int PAST_DEPTH    = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	localparam int CA = (CURRENT_DEPTH > 1) ? $clog2(CURRENT_DEPTH) : 1;
	localparam int CW = $clog2(CURRENT_DEPTH + 1);
	localparam int PA = $clog2(PAST_DEPTH);
	localparam int PW = $clog2(PAST_DEPTH + 1);
	localparam int SW = ((PW > CW) ? PW : CW) + 1;
	localparam int PE = $bits(past_entry_t);

	typedef enum logic [4:0] {
		S_IDLE, S_IN_RD, S_IN_CMP, S_RC_DATA, S_RP_DATA,
		S_BS_LOOP, S_BS_CMP, S_BS_HITC, S_FIND_END,
		S_A1_RD, S_A1_KEY, S_A1_NEXT, S_A2_RD, S_A2_KEY, S_A2_UPD,
		S_SH_RD, S_SH_WR, S_DONE
	} state_t;

	state_t            state_q, ret_q;
	logic [CW-1:0]     cur_fill_q, i_q, fresh_q;
	logic [PW-1:0]     past_fill_q, lo_q, hi_q, j_q;
	logic [TICK_W-1:0] now_q, target_q;
	logic              known_q, hit_q;
	logic [ID_W-1:0]   key_q;
	res_t              wr_q;
	res_t              res_q;
	logic              res_valid_q;

	logic              cur_we;
	logic [CA-1:0]     cur_waddr, cur_raddr;
	logic [ID_W-1:0]   cur_wdata, cur_rdata;
	logic              past_we;
	logic [PA-1:0]     past_waddr, past_raddr;
	past_entry_t       past_wdata, past_rd;
	logic [PE-1:0]     past_rdata;

	logic [31:0]       idx_ext;
	logic [PW:0]       mid_sum;
	logic [PW-1:0]     mid;
	logic [SW-1:0]     need;
	past_entry_t       new_ent;

	assign idx_ext = 32'(req.entry_index);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[PW:1];
	assign need    = SW'(past_fill_q) + SW'(fresh_q);
	assign past_rd = past_entry_t'(past_rdata);

	always_comb begin
		new_ent.id    = key_q;
		new_ent.tick  = known_q ? now_q : '0;
		new_ent.never = ~known_q;
	end

	erc_ram #(.WIDTH(ID_W), .DEPTH(CURRENT_DEPTH), .AW(CA)) u_cur (
		.clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
		.raddr(cur_raddr), .rdata(cur_rdata)
	);

	erc_ram #(.WIDTH(PE), .DEPTH(PAST_DEPTH), .AW(PA)) u_past (
		.clk(clk), .we(past_we), .waddr(past_waddr), .wdata(PE'(past_wdata)),
		.raddr(past_raddr), .rdata(past_rdata)
	);

	always_comb begin
		cur_we     = 1'b0;
		cur_waddr  = cur_fill_q[CA-1:0];
		cur_wdata  = key_q;
		cur_raddr  = i_q[CA-1:0];
		past_we    = 1'b0;
		past_waddr = lo_q[PA-1:0];
		past_wdata = new_ent;
		past_raddr = lo_q[PA-1:0];
		unique case (state_q)
			S_IDLE: begin
				cur_raddr  = idx_ext[CA-1:0];
				past_raddr = idx_ext[PA-1:0];
			end
			S_IN_RD: begin
				cur_we = (i_q >= cur_fill_q) && (32'(cur_fill_q) < 32'(CURRENT_DEPTH));
			end
			S_BS_LOOP: begin
				past_raddr = (lo_q < hi_q) ? mid[PA-1:0] : lo_q[PA-1:0];
			end
			S_A2_UPD: begin
				past_we = hit_q;
			end
			S_SH_RD: begin
				past_raddr = PA'(j_q - 1'b1);
				past_we    = (j_q <= lo_q);
			end
			S_SH_WR: begin
				past_we    = 1'b1;
				past_waddr = j_q[PA-1:0];
				past_wdata = past_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_FIND_END;
			cur_fill_q  <= '0;
			past_fill_q <= '0;
			now_q       <= '0;
			known_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						wr_q     <= '0;
						key_q    <= req.event_id;
						target_q <= req.new_time;
						i_q      <= '0;
						fresh_q  <= '0;
						lo_q     <= '0;
						hi_q     <= past_fill_q;
						state_q  <= S_DONE;
						case (req.command)
							CMD_INSERT: state_q <= S_IN_RD;
							CMD_ADVANCE: begin
								if (known_q && req.new_time < now_q) begin
									wr_q.status <= ST_BACKWARDS;
								end else if (!(known_q && req.new_time == now_q)) begin
									state_q <= S_A1_RD;
								end
							end
							CMD_RD_CUR: begin
								if (32'(cur_fill_q) <= idx_ext) begin
									wr_q.status <= ST_BAD_INDEX;
								end else begin
									state_q <= S_RC_DATA;
								end
							end
							CMD_RD_PAST: begin
								if (32'(past_fill_q) <= idx_ext) begin
									wr_q.status <= ST_BAD_INDEX;
								end else begin
									state_q <= S_RP_DATA;
								end
							end
							CMD_FIND: begin
								ret_q   <= S_FIND_END;
								state_q <= S_BS_LOOP;
							end
							CMD_CLEAR: begin
								cur_fill_q  <= '0;
								past_fill_q <= '0;
								now_q       <= '0;
								known_q     <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_IN_RD: begin
					if (i_q < cur_fill_q) begin
						state_q <= S_IN_CMP;
					end else begin
						if (32'(cur_fill_q) < 32'(CURRENT_DEPTH)) begin
							cur_fill_q <= cur_fill_q + 1'b1;
						end else begin
							wr_q.status <= ST_CUR_FULL;
						end
						state_q <= S_DONE;
					end
				end
				S_IN_CMP: begin
					i_q     <= i_q + 1'b1;
					state_q <= (cur_rdata == key_q) ? S_DONE : S_IN_RD;
				end
				S_RC_DATA: begin
					wr_q.read_event_id <= cur_rdata;
					state_q            <= S_DONE;
				end
				S_RP_DATA: begin
					wr_q.read_event_id <= past_rd.id;
					if (!known_q || past_rd.never) begin
						wr_q.elapsed_infinite <= 1'b1;
					end else begin
						wr_q.elapsed <= now_q - past_rd.tick;
					end
					state_q <= S_DONE;
				end
				S_BS_LOOP: begin
					if (lo_q < hi_q) begin
						state_q <= S_BS_CMP;
					end else if (lo_q < past_fill_q) begin
						state_q <= S_BS_HITC;
					end else begin
						hit_q   <= 1'b0;
						state_q <= ret_q;
					end
				end
				S_BS_CMP: begin
					if (past_rd.id < key_q) begin
						lo_q <= mid + 1'b1;
					end else begin
						hi_q <= mid;
					end
					state_q <= S_BS_LOOP;
				end
				S_BS_HITC: begin
					hit_q   <= (past_rd.id == key_q);
					state_q <= ret_q;
				end
				S_FIND_END: begin
					wr_q.found       <= hit_q;
					wr_q.found_index <= 11'(lo_q);
					state_q          <= S_DONE;
				end
				S_A1_RD: begin
					if (i_q < cur_fill_q) begin
						state_q <= S_A1_KEY;
					end else if (need > SW'(PAST_DEPTH)) begin
						wr_q.status <= ST_PAST_FULL;
						state_q     <= S_DONE;
					end else begin
						i_q     <= '0;
						state_q <= S_A2_RD;
					end
				end
				S_A1_KEY: begin
					key_q   <= cur_rdata;
					lo_q    <= '0;
					hi_q    <= past_fill_q;
					ret_q   <= S_A1_NEXT;
					state_q <= S_BS_LOOP;
				end
				S_A1_NEXT: begin
					if (!hit_q) begin
						fresh_q <= fresh_q + 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_A1_RD;
				end
				S_A2_RD: begin
					if (i_q < cur_fill_q) begin
						state_q <= S_A2_KEY;
					end else begin
						cur_fill_q <= '0;
						now_q      <= target_q;
						known_q    <= 1'b1;
						state_q    <= S_DONE;
					end
				end
				S_A2_KEY: begin
					key_q   <= cur_rdata;
					lo_q    <= '0;
					hi_q    <= past_fill_q;
					ret_q   <= S_A2_UPD;
					state_q <= S_BS_LOOP;
				end
				S_A2_UPD: begin
					if (hit_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_A2_RD;
					end else begin
						j_q     <= past_fill_q;
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					if (j_q > lo_q) begin
						state_q <= S_SH_WR;
					end else begin
						past_fill_q <= past_fill_q + 1'b1;
						i_q         <= i_q + 1'b1;
						state_q     <= S_A2_RD;
					end
				end
				S_SH_WR: begin
					j_q     <= j_q - 1'b1;
					state_q <= S_SH_RD;
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_q               <= wr_q;
						res_q.current_count <= 7'(cur_fill_q);
						res_q.past_count    <= 11'(past_fill_q);
						res_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire
